// ===== rtl/clrm_pkg.sv =====
// Package for the clamped linear range map: field widths, register indexes
// and register reset values. No dependencies.
package clrm_pkg;

    localparam int FIELD_W         = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_LOW   = 2'd0,
        REG_IN_HIGH  = 2'd1,
        REG_OUT_LOW  = 2'd2,
        REG_OUT_HIGH = 2'd3
    } t_reg_idx;

    localparam logic [FIELD_W-1:0] RST_IN_LOW   = 32'd0;
    localparam logic [FIELD_W-1:0] RST_IN_HIGH  = 32'd4095;
    localparam logic [FIELD_W-1:0] RST_OUT_LOW  = 32'd0;
    localparam logic [FIELD_W-1:0] RST_OUT_HIGH = 32'd1000;

endpackage

// ===== rtl/clamped_linear_range_map_top.sv =====
// Clamped linear range map: a start passes through stage 1, the divider stages and the strobe register.
// Throughput is one request per cycle; busy is always low and the result side never stalls.
// The quotient comes from a restoring divider with one pipeline stage per quotient bit.
// Synchronous active-low reset clears the stage valid bits and restores register defaults.
// Depends on clrm_pkg.
module clamped_linear_range_map_top
    import clrm_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [FIELD_W-1:0]   i_sample_value,
    output logic                 o_strobe,
    output logic [FIELD_W-1:0]   o_scaled_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data
);

    localparam int W = VALUE_WIDTH;

    logic [FIELD_W-1:0] r_in_low, r_in_high, r_out_low, r_out_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_low   <= RST_IN_LOW;
            r_in_high  <= RST_IN_HIGH;
            r_out_low  <= RST_OUT_LOW;
            r_out_high <= RST_OUT_HIGH;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_IN_LOW:   r_in_low   <= i_cfg_data;
                REG_IN_HIGH:  r_in_high  <= i_cfg_data;
                REG_OUT_LOW:  r_out_low  <= i_cfg_data;
                REG_OUT_HIGH: r_out_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Users hold configuration static while requests are in flight, unenforced; all stages read it.
    logic signed [W:0]   w_a, w_b, w_c, w_d, w_x;
    logic signed [W:0]   w_din, w_dy, w_dx, w_xc, w_lo_in, w_hi_in;
    logic [W-1:0]        w_mdin, w_mdy, w_mdx;
    logic                w_asc, w_degen, w_neg;

    assign w_a = {r_in_low[W-1], r_in_low[W-1:0]};
    assign w_b = {r_in_high[W-1], r_in_high[W-1:0]};
    assign w_c = {r_out_low[W-1], r_out_low[W-1:0]};
    assign w_d = {r_out_high[W-1], r_out_high[W-1:0]};
    assign w_x = {i_sample_value[W-1], i_sample_value[W-1:0]};

    assign w_degen = (w_a == w_b);
    assign w_asc   = (w_a < w_b);
    assign w_lo_in = w_asc ? w_a : w_b;
    assign w_hi_in = w_asc ? w_b : w_a;

    always_comb begin
        if (w_x < w_lo_in) begin
            w_xc = w_lo_in;
        end else if (w_x > w_hi_in) begin
            w_xc = w_hi_in;
        end else begin
            w_xc = w_x;
        end
    end

    logic signed [W:0] w_din_abs, w_dy_abs, w_dx_abs;

    assign w_din     = w_b - w_a;
    assign w_dy      = w_d - w_c;
    assign w_dx      = w_xc - w_a;
    assign w_din_abs = w_din[W] ? -w_din : w_din;
    assign w_dy_abs  = w_dy[W] ? -w_dy : w_dy;
    assign w_dx_abs  = w_dx[W] ? -w_dx : w_dx;
    assign w_mdin    = w_din_abs[W-1:0];
    assign w_mdy     = w_dy_abs[W-1:0];
    assign w_mdx     = w_dx_abs[W-1:0];
    assign w_neg     = w_dx[W] ^ w_dy[W] ^ w_din[W];

    // Stage 1: clamped offset magnitude and result sign.
    logic         r_s1_valid, r_s1_neg;
    logic [W-1:0] r_s1_mdx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
        end
        r_s1_mdx <= w_mdx;
        r_s1_neg <= w_neg;
    end

    // Stage 2 is divider index 0: the product enters as remainder and low dividend bits.
    logic         r_valid [0:W];
    logic         r_neg   [0:W];
    logic [W-1:0] r_rem   [0:W];
    logic [W-1:0] r_low   [0:W];
    logic [W-1:0] r_q     [0:W];
    logic [W-1:0] n_rem   [0:W-1];
    logic [W-1:0] n_q     [0:W-1];
    logic [W:0]   w_trial [0:W-1];
    logic [2*W-1:0] w_prod;

    assign w_prod = (2*W)'(r_s1_mdx) * (2*W)'(w_mdy);

    always_comb begin
        for (int k = 0; k < W; k++) begin
            w_trial[k] = {r_rem[k], r_low[k][W-1]};
            if (w_trial[k] >= {1'b0, w_mdin}) begin
                n_rem[k] = W'(w_trial[k] - {1'b0, w_mdin});
                n_q[k]   = {r_q[k][W-2:0], 1'b1};
            end else begin
                n_rem[k] = w_trial[k][W-1:0];
                n_q[k]   = {r_q[k][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_valid[0] <= r_s1_valid;
            for (int k = 0; k < W; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
        end
        r_rem[0] <= w_prod[2*W-1:W];
        r_low[0] <= w_prod[W-1:0];
        r_q[0]   <= '0;
        r_neg[0] <= r_s1_neg;
        for (int k = 0; k < W; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_low[k+1] <= {r_low[k][W-2:0], 1'b0};
            r_q[k+1]   <= n_q[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    // Final stage: apply sign and offset, clamp, or take the midpoint for a flat input range.
    logic signed [W+1:0] w_c2, w_d2, w_q2, w_sum, w_lo_out, w_hi_out, w_clamped, w_half;
    logic signed [W:0]   w_dy_half;
    logic signed [W+1:0] w_final;
    logic signed [W-1:0] w_res;
    logic                r_strobe;
    logic [FIELD_W-1:0]  r_mapped;

    assign w_c2     = {w_c[W], w_c};
    assign w_d2     = {w_d[W], w_d};
    assign w_q2     = {2'b00, r_q[W]};
    assign w_sum    = r_neg[W] ? (w_c2 - w_q2) : (w_c2 + w_q2);
    assign w_lo_out = (w_c2 < w_d2) ? w_c2 : w_d2;
    assign w_hi_out = (w_c2 < w_d2) ? w_d2 : w_c2;

    always_comb begin
        if (w_sum < w_lo_out) begin
            w_clamped = w_lo_out;
        end else if (w_sum > w_hi_out) begin
            w_clamped = w_hi_out;
        end else begin
            w_clamped = w_sum;
        end
    end

    assign w_dy_half = $signed(w_dy + {{W{1'b0}}, w_dy[W]}) >>> 1;
    assign w_half    = w_c2 + {w_dy_half[W], w_dy_half};
    assign w_final   = w_degen ? w_half : w_clamped;
    assign w_res     = w_final[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_valid[W];
        end
        r_mapped <= FIELD_W'(w_res);
    end

    assign o_busy         = 1'b0;
    assign o_strobe       = r_strobe;
    assign o_scaled_value = r_mapped;

endmodule
